### design/mctt_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mctt_pkg: shared types and constants for the multi-channel tick timer
// Channel count, counter width, word layouts, operation and status codes,
// and the command/status bundles between controller and datapath.
// -----------------------------------------------------------------------------
package mctt_pkg;

   // Table size and counter width
   localparam int NUM_CHANNELS = 16;
   localparam int COUNT_WIDTH  = 16;
   localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Field widths of the words
   localparam int OP_W     = 2;
   localparam int CHAN_W   = 4;
   localparam int VALUE_W  = 16;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 16;

   // Stream word widths (padded to whole bytes)
   localparam int REQ_USER_W = OP_W;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int REQ_PAD_W  = REQ_DATA_W - CHAN_W - VALUE_W - 1;
   localparam int RSP_PAD_W  = RSP_DATA_W - STATUS_W - MASK_W;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_INIT  = 2'd1,
      OP_START = 2'd2,
      OP_STOP  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_RUNNING = 2'd1,
      ST_UNREG   = 2'd2
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // request word taken this cycle
      logic run;       // execute op, or one channel of the tick sweep
      logic load_out;  // move result into the response register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_tick;    // latched op is a tick
      logic walk_last;  // sweep is at the last channel
   } dp_sts_type;

   // Channel number to table index
   function automatic logic [IDX_W-1:0] chan_index(input logic [CHAN_W-1:0] ch);
      logic [IDX_W+CHAN_W-1:0] wide;
      wide = {{IDX_W{1'b0}}, ch};
      return wide[IDX_W-1:0];
   endfunction

   // Channel number lies inside the table
   function automatic logic chan_valid(input logic [CHAN_W-1:0] ch);
      logic [IDX_W+CHAN_W:0] wide;
      wide = {{(IDX_W+1){1'b0}}, ch};
      return wide < (IDX_W+CHAN_W+1)'(NUM_CHANNELS);
   endfunction

   // Reload field trimmed or extended to the counter width
   function automatic logic [COUNT_WIDTH-1:0] fit_count(input logic [VALUE_W-1:0] v);
      logic [COUNT_WIDTH+VALUE_W-1:0] wide;
      wide = {{COUNT_WIDTH{1'b0}}, v};
      return wide[COUNT_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

### design/multi_channel_tick_timer.sv
`default_nettype none
// -----------------------------------------------------------------------------
// multi_channel_tick_timer: table of down-counting timer channels
// Init, start, stop and tick operations on NUM_CHANNELS timers, one result
// word (status and fired mask) per request word.
// -----------------------------------------------------------------------------
// One request word is handled at a time. An init, start or stop passes
// through the run and done states once; a tick stays in the run state while
// it sweeps the count memory one channel per cycle, over all NUM_CHANNELS
// channels. A finished result sits in an output
// register, so the next word is taken while the previous result still waits.
// Count and reload of a channel hold no defined value until its first init.
module multi_channel_tick_timer
   import mctt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [3:0] channel, [19:4] reload_value, [20] periodic_request, rest zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [1:0] status, [17:2] fired_mask, rest zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   mctt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   mctt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTHESIS
   // One word at a time: no acceptance in the cycle after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous word in progress");

   // A word with fired channels comes from a tick, which always reports ok
   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[STATUS_W +: MASK_W] != '0))
         |-> (rsp_tdata[STATUS_W-1:0] == ST_OK))
      else $error("fired mask with non-ok status");

   // Status is always a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[STATUS_W-1:0] == ST_OK
                      || rsp_tdata[STATUS_W-1:0] == ST_RUNNING
                      || rsp_tdata[STATUS_W-1:0] == ST_UNREG))
      else $error("undefined status code");
`endif

endmodule
`default_nettype wire

### design/mctt_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mctt_ctrl: sequencing controller
// Takes one request word at a time, runs it through the datapath (a run of
// the operation, or a sweep over all channels for a tick) and hands the result word out.
// -----------------------------------------------------------------------------
module mctt_ctrl
   import mctt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output ctrl_cmd_type      cmd,
   input  wire dp_sts_type   sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;

   // Output register can take a new word
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Commands
   assign req_tready   = (state_ff == S_IDLE);
   assign cmd.accept   = req_tvalid && (state_ff == S_IDLE);
   assign cmd.run      = (state_ff == S_RUN);
   assign cmd.load_out = (state_ff == S_DONE) && out_free;
   assign rsp_tvalid   = rsp_tvalid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_RUN;
         end
         S_RUN: begin
            if (!sts.is_tick || sts.walk_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Response valid: set on load, cleared when taken
   always_comb begin
      priority if (cmd.load_out) rsp_tvalid_in = 1'b1;
      else if (rsp_tready)       rsp_tvalid_in = 1'b0;
      else                       rsp_tvalid_in = rsp_tvalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule
`default_nettype wire

### design/mctt_datapath.sv
`default_nettype none
// -----------------------------------------------------------------------------
// mctt_datapath: timer table and operation logic
// Holds count and reload memories, per-channel flags, the latched request
// and the result registers. A tick sweeps the count memory one channel a cycle.
// -----------------------------------------------------------------------------
module mctt_datapath
   import mctt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire ctrl_cmd_type          cmd,
   output dp_sts_type                 sts,
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   // Table memories (contents undefined until init)
   logic [COUNT_WIDTH-1:0] count_mem  [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0] reload_mem [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0] count_rd_ff, reload_rd_ff;

   // Per-channel flags
   logic [NUM_CHANNELS-1:0] running_ff, running_in;
   logic [NUM_CHANNELS-1:0] periodic_ff, periodic_in;
   logic [NUM_CHANNELS-1:0] registered_ff, registered_in;

   // Latched request
   op_type             op_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               preq_ff;

   // Sweep index and results
   logic [IDX_W-1:0]      idx_ff, idx_in;
   status_type            status_ff, status_in;
   logic [MASK_W-1:0]     fired_ff, fired_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Incoming word fields
   op_type            req_op;
   logic [CHAN_W-1:0] req_chan;
   assign req_op   = op_type'(req_tuser[OP_W-1:0]);
   assign req_chan = req_tdata[CHAN_W-1:0];

   // Memory control
   logic [IDX_W-1:0]       rd_addr;
   logic                   count_we, reload_we;
   logic [IDX_W-1:0]       wr_addr;
   logic [COUNT_WIDTH-1:0] count_wd;

   logic [IDX_W-1:0]  c_idx;
   logic              c_valid;
   logic [MASK_W-1:0] hit;

   assign c_idx   = chan_index(chan_ff);
   assign c_valid = chan_valid(chan_ff);

   // Read address: first channel or addressed channel at accept, next channel in sweep
   always_comb begin
      if (cmd.accept) begin
         rd_addr = (req_op == OP_TICK) ? '0 : chan_index(req_chan);
      end else begin
         rd_addr = idx_ff + 1'b1;
      end
   end

   // Mask bit for the current sweep channel
   always_comb begin
      for (int j = 0; j < MASK_W; j++) begin
         hit[j] = ({{(CHAN_W+1){1'b0}}, idx_ff} == (IDX_W+CHAN_W+1)'(j));
      end
   end

   // Operation logic
   always_comb begin
      running_in    = running_ff;
      periodic_in   = periodic_ff;
      registered_in = registered_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      fired_in      = fired_ff;
      count_we      = 1'b0;
      reload_we     = 1'b0;
      wr_addr       = c_idx;
      count_wd      = fit_count(value_ff);
      if (cmd.accept) begin
         idx_in    = '0;
         status_in = ST_OK;
         fired_in  = '0;
      end else if (cmd.run) begin
         unique case (op_ff)
            OP_TICK: begin
               wr_addr = idx_ff;
               idx_in  = idx_ff + 1'b1;
               if (registered_ff[idx_ff] && running_ff[idx_ff]) begin
                  if (count_rd_ff != '0) begin
                     count_we = 1'b1;
                     count_wd = count_rd_ff - 1'b1;
                  end else begin
                     fired_in = fired_ff | hit;
                     if (periodic_ff[idx_ff]) begin
                        count_we = 1'b1;
                        count_wd = reload_rd_ff;
                     end else begin
                        running_in[idx_ff] = 1'b0;
                     end
                  end
               end
            end
            OP_INIT: begin
               if (!c_valid) begin
                  status_in = ST_UNREG;
               end else begin
                  registered_in[c_idx] = 1'b1;
                  running_in[c_idx]    = 1'b0;
                  periodic_in[c_idx]   = 1'b0;
                  count_we             = 1'b1;
                  reload_we            = 1'b1;
               end
            end
            OP_START: begin
               priority if (!c_valid || !registered_ff[c_idx]) begin
                  status_in = ST_UNREG;
               end else if (running_ff[c_idx]) begin
                  status_in = ST_RUNNING;
               end else begin
                  running_in[c_idx] = 1'b1;
                  if (preq_ff) periodic_in[c_idx] = 1'b1;
               end
            end
            OP_STOP: begin
               if (!c_valid || !registered_ff[c_idx]) begin
                  status_in = ST_UNREG;
               end else begin
                  running_in[c_idx]  = 1'b0;
                  periodic_in[c_idx] = 1'b0;
                  count_we           = 1'b1;
                  count_wd           = reload_rd_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (count_we) count_mem[wr_addr] <= count_wd;
      if (reload_we) reload_mem[wr_addr] <= fit_count(value_ff);
      count_rd_ff  <= count_mem[rd_addr];
      reload_rd_ff <= reload_mem[rd_addr];
   end

   // Flags
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= '0;
         periodic_ff   <= '0;
         registered_ff <= '0;
      end else begin
         running_ff    <= running_in;
         periodic_ff   <= periodic_in;
         registered_ff <= registered_in;
      end
   end

   // Request latch, sweep index, results
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_op;
         chan_ff  <= req_chan;
         value_ff <= req_tdata[CHAN_W +: VALUE_W];
         preq_ff  <= req_tdata[CHAN_W+VALUE_W];
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
      fired_ff  <= fired_in;
      if (cmd.load_out) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, fired_ff, status_ff};
      end
   end

   assign sts.is_tick   = (op_ff == OP_TICK);
   assign sts.walk_last = (idx_ff == IDX_W'(NUM_CHANNELS - 1));
   assign rsp_tdata     = rsp_data_ff;

endmodule
`default_nettype wire

### dv/mctt_checker.sv
// -----------------------------------------------------------------------------
// mctt_checker: response checker for the multi-channel tick timer
// Watches the request and response streams, keeps its own copy of the timer
// table, works out the result word for every accepted request and compares
// each accepted response, field by field, with the oldest one still awaited.
// -----------------------------------------------------------------------------
module mctt_checker
   import mctt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // [3:0] channel, [19:4] reload_value, [20] periodic_request, rest zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [1:0] status, [17:2] fired_mask, rest zero
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                         mismatches,
   output int                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type        status;
      logic [MASK_W-1:0] fired;
   } timer_result_type;

   // Shadow timer table
   logic [COUNT_WIDTH-1:0] chan_count      [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0] chan_reload     [NUM_CHANNELS];
   logic                   chan_running    [NUM_CHANNELS];
   logic                   chan_periodic   [NUM_CHANNELS];
   logic                   chan_registered [NUM_CHANNELS];

   timer_result_type awaited_results[$];

   // One tick over the whole table: count down, fire, reload or stop
   function automatic logic [MASK_W-1:0] sweep_tick();
      logic [MASK_W-1:0] fired;
      fired = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (chan_registered[i] && chan_running[i]) begin
            if (chan_count[i] != '0) begin
               chan_count[i] = chan_count[i] - 1'b1;
            end else begin
               if (i < MASK_W) fired[i] = 1'b1;
               if (chan_periodic[i]) chan_count[i] = chan_reload[i];
               else chan_running[i] = 1'b0;
            end
         end
      end
      return fired;
   endfunction

   // Apply one request word to the shadow table and return its result word
   function automatic timer_result_type apply_timer_op(
      input op_type            op,
      input logic [CHAN_W-1:0] ch,
      input logic [VALUE_W-1:0] value,
      input logic              per_req
   );
      timer_result_type res;
      logic          in_table;
      int            idx;
      res.status = ST_OK;
      res.fired  = '0;
      in_table   = int'(ch) < NUM_CHANNELS;
      idx        = in_table ? int'(ch) : 0;
      case (op)
         OP_TICK: begin
            res.fired = sweep_tick();
         end
         OP_INIT: begin
            if (!in_table) begin
               res.status = ST_UNREG;
            end else begin
               chan_registered[idx] = 1'b1;
               chan_count[idx]      = COUNT_WIDTH'(value);
               chan_reload[idx]     = COUNT_WIDTH'(value);
               chan_running[idx]    = 1'b0;
               chan_periodic[idx]   = 1'b0;
            end
         end
         OP_START: begin
            if (!in_table || !chan_registered[idx]) begin
               res.status = ST_UNREG;
            end else if (chan_running[idx]) begin
               res.status = ST_RUNNING;
            end else begin
               if (per_req) chan_periodic[idx] = 1'b1;
               chan_running[idx] = 1'b1;
            end
         end
         default: begin
            if (!in_table || !chan_registered[idx]) begin
               res.status = ST_UNREG;
            end else begin
               chan_running[idx]  = 1'b0;
               chan_periodic[idx] = 1'b0;
               chan_count[idx]    = chan_reload[idx];
            end
         end
      endcase
      return res;
   endfunction

   // Sample both streams at the edge; responses first so an unexpected
   // word is never matched against a request taken at the same edge
   always @(posedge clock) begin
      timer_result_type want;
      status_type    got_status;
      logic [MASK_W-1:0] got_fired;
      if (reset) begin
         awaited_results.delete();
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_running[i]    = 1'b0;
            chan_periodic[i]   = 1'b0;
            chan_registered[i] = 1'b0;
         end
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_status = status_type'(rsp_tdata[STATUS_W-1:0]);
            got_fired  = rsp_tdata[STATUS_W +: MASK_W];
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected response word, status %0d fired %h",
                        $time, got_status, got_fired);
               mismatches = mismatches + 1;
            end else begin
               want = awaited_results.pop_front();
               if (got_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, got_status);
                  mismatches = mismatches + 1;
               end
               if (got_fired !== want.fired) begin
                  $display("%0t: fired mask mismatch, expected %h, actual %h",
                           $time, want.fired, got_fired);
                  mismatches = mismatches + 1;
               end
               if (rsp_tdata[RSP_DATA_W-1:STATUS_W+MASK_W] !== '0) begin
                  $display("%0t: response padding mismatch, expected 0, actual %h",
                           $time, rsp_tdata[RSP_DATA_W-1:STATUS_W+MASK_W]);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(apply_timer_op(
               op_type'(req_tuser),
               req_tdata[CHAN_W-1:0],
               req_tdata[CHAN_W +: VALUE_W],
               req_tdata[CHAN_W+VALUE_W]));
         end
      end
      outstanding = awaited_results.size();
   end

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

endmodule

### dv/tb_multi_channel_tick_timer.sv
// -----------------------------------------------------------------------------
// tb_multi_channel_tick_timer: stimulus and verdict for the tick timer
// Drives a directed sequence of timer operations followed by random ones,
// with random gaps on the request side, random and one long stall on the
// response side; the checker beside the block predicts and compares.
// -----------------------------------------------------------------------------
module tb_multi_channel_tick_timer;
   import mctt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS   = 1230;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = NUM_CHANNELS + 8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [3:0] channel, [19:4] reload, [20] periodic
   logic [REQ_USER_W-1:0] req_tuser;   // [1:0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [1:0] status, [17:2] fired mask
   int                    mismatches;
   int                    outstanding;
   int                    rsp_seen;
   int                    quiet_cycles;
   logic                  no_gaps;

   multi_channel_tick_timer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mctt_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one request word and wait for it to be taken; valid is only
   // lowered when a gap follows, never dropped and raised in one step
   task automatic push_word(input op_type op, input logic [CHAN_W-1:0] ch,
                            input logic [VALUE_W-1:0] value, input logic per_req);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, per_req, value, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   // Random word: well-formed timer use with small reloads most of the time
   task automatic push_random_word();
      int                 r;
      op_type             op;
      logic [VALUE_W-1:0] value;
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_TICK;
      else if (r < 65) op = OP_INIT;
      else if (r < 85) op = OP_START;
      else op = OP_STOP;
      r = $urandom_range(0, 99);
      if (r < 80) value = VALUE_W'($urandom_range(0, 4));
      else if (r < 95) value = VALUE_W'($urandom_range(5, 40));
      else value = VALUE_W'($urandom_range(0, 65535));
      push_word(op, CHAN_W'($urandom_range(0, 15)), value, 1'($urandom_range(0, 1)));
   endtask

   // Response side: ready bursts and stalls, plus one long hold mid-run
   initial begin
      int  run_len;
      int  stall;
      logic held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run_len = $urandom_range(1, 20);
         rsp_tready <= 1'b1;
         repeat (run_len) @(posedge clock);
         stall = pick_gap();
         if (!held && rsp_seen >= 300) begin
            held  = 1'b1;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_seen <= 0;
      else if (rsp_tvalid && rsp_tready) rsp_seen <= rsp_seen + 1;
   end

   // Watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("** multi_channel_tick_timer: FAILED **");
            $finish;
         end
      end
   end

   // Main stimulus
   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= OP_TICK;
      no_gaps      <= 1'b0;
      quiet_cycles <= 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table, unregistered channels
      push_word(OP_TICK, 4'd0, 16'h0000, 1'b0);
      push_word(OP_START, 4'd3, 16'hFFFF, 1'b1);
      push_word(OP_STOP, 4'd3, 16'h0000, 1'b0);
      // Reload extremes; one-shot fires at once from zero
      push_word(OP_INIT, 4'd0, 16'h0000, 1'b0);
      push_word(OP_INIT, 4'd15, 16'hFFFF, 1'b1);
      push_word(OP_START, 4'd0, 16'h0000, 1'b0);
      push_word(OP_START, 4'd0, 16'h0000, 1'b1);   // already running
      push_word(OP_TICK, 4'd0, 16'h0000, 1'b0);
      push_word(OP_TICK, 4'd0, 16'h0000, 1'b0);
      // Periodic channel reloads after firing; a start while it runs is refused
      push_word(OP_INIT, 4'd1, 16'h0002, 1'b0);
      push_word(OP_START, 4'd1, 16'h0000, 1'b1);
      repeat (4) push_word(OP_TICK, 4'd0, 16'h0000, 1'b0);
      push_word(OP_START, 4'd1, 16'h0000, 1'b0);
      push_word(OP_TICK, 4'd0, 16'h0000, 1'b0);
      push_word(OP_TICK, 4'd0, 16'h0000, 1'b0);
      push_word(OP_STOP, 4'd1, 16'h0000, 1'b1);
      // Re-init of a registered channel, stop of a running one
      push_word(OP_INIT, 4'd1, 16'h0005, 1'b1);
      push_word(OP_START, 4'd15, 16'h0000, 1'b1);
      push_word(OP_TICK, 4'd0, 16'h0000, 1'b0);
      push_word(OP_STOP, 4'd15, 16'h0000, 1'b0);
      push_word(OP_INIT, 4'd7, 16'hAAAA, 1'b0);
      push_word(OP_INIT, 4'd8, 16'h5555, 1'b1);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         no_gaps <= (n >= 700 && n < 900);
         push_random_word();
      end
      req_tvalid <= 1'b0;

      // Let the checker log the last request, drain, then let the block settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("** multi_channel_tick_timer: PASSED **");
      end else begin
         $display("** multi_channel_tick_timer: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
design/mctt_pkg.sv
design/mctt_ctrl.sv
design/mctt_datapath.sv
design/multi_channel_tick_timer.sv
dv/mctt_checker.sv
dv/tb_multi_channel_tick_timer.sv
